### rtl/assert_macros.svh
// assertion macros shared by the quaternion unit rtl
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property checked on every clock edge outside reset
`define QAU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);
// condition in the cycle after a trigger
`define QAU_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`endif

### rtl/qau_pkg.sv
// shared constants, types and rounding helpers of the quaternion unit
// no dependencies
package qau_pkg;
	localparam int DW = 32;
	localparam int FB = 16;
	localparam int AW = 3;
	localparam int PW = 2*DW + 2;
	localparam int SW = 2*DW + 1;
	localparam int RW = DW + 1;
	localparam int NW = DW + 2*FB;
	localparam int XW = 2*DW + 2*FB + 4;
	localparam int CW = $clog2(NW + 1);
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);
	localparam int IDW = 8*DW;
	localparam int ODW = ((4*DW + 2 + 7) / 8) * 8;

	localparam logic [AW-1:0] ACT_MUL  = 3'd0;
	localparam logic [AW-1:0] ACT_ADD  = 3'd1;
	localparam logic [AW-1:0] ACT_SUB  = 3'd2;
	localparam logic [AW-1:0] ACT_CONJ = 3'd3;
	localparam logic [AW-1:0] ACT_NORM = 3'd4;
	localparam logic [AW-1:0] ACT_INV  = 3'd5;

	typedef logic [DW-1:0] comp_t;

	typedef struct packed {
		logic [AW-1:0] act;
		logic          slow;
		comp_t [3:0]   a;
		comp_t [3:0]   b;
	} item_t;

	typedef struct packed {
		comp_t v;
		logic  ovf;
	} sat_t;

	// clamp a wide signed value to DW bits
	function automatic sat_t saturate(input logic signed [XW-1:0] v);
		sat_t r;
		r.ovf = !((&v[XW-1:DW-1]) || !(|v[XW-1:DW-1]));
		if (!r.ovf) begin
			r.v = v[DW-1:0];
		end else if (v[XW-1]) begin
			r.v = {1'b1, {(DW-1){1'b0}}};
		end else begin
			r.v = {1'b0, {(DW-1){1'b1}}};
		end
		return r;
	endfunction

	// drop FB fraction bits, round half away from zero
	function automatic logic signed [XW-1:0] round_frac(input logic signed [PW-1:0] t);
		logic signed [PW:0] tx;
		logic [PW:0] m;
		logic signed [XW-1:0] mx;
		tx = {t[PW-1], t};
		m = t[PW-1] ? -tx : tx;
		m = m + ((PW+1)'(1) << (FB-1));
		m = m >> FB;
		mx = XW'(m);
		return t[PW-1] ? -mx : mx;
	endfunction
endpackage

### rtl/qau_front.sv
// front end: input register, operand unpacking and op classification
// depends on qau_pkg
module qau_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [qau_pkg::IDW-1:0] s_axis_tdata,  // a_w a_x a_y a_z b_w b_x b_y b_z
	input  logic [qau_pkg::AW-1:0]  s_axis_tuser,  // action
	output logic                  q_valid,
	input  logic                  q_ready,
	output qau_pkg::item_t        q_data
);
	import qau_pkg::*;

	item_t item_q;
	logic  valid_q;

	assign s_axis_tready = !valid_q || q_ready;
	assign q_valid = valid_q;
	assign q_data = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_q.act <= s_axis_tuser;
			// norm and inverse are marked slow; the back end runs them, but for an inverse of zero, in the iterative unit
			item_q.slow <= (s_axis_tuser == ACT_NORM) || (s_axis_tuser == ACT_INV);
			for (int i = 0; i < 4; i++) begin
				item_q.a[i] <= s_axis_tdata[i*DW +: DW];
				item_q.b[i] <= s_axis_tdata[(4+i)*DW +: DW];
			end
		end
	end
endmodule

### rtl/qau_queue.sv
// short register queue between front and back
// depends on qau_pkg and assert_macros.svh
`include "assert_macros.svh"
module qau_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  qau_pkg::item_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output qau_pkg::item_t out_data
);
	import qau_pkg::*;

	item_t          mem_q [QDEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QAW:0]   cnt_q;
	logic           push;
	logic           pop;

	assign in_ready = cnt_q != (QAW+1)'(QDEPTH);
	assign out_valid = cnt_q != '0;
	assign out_data = mem_q[rd_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_data;
	end

	`QAU_ASSERT(a_q_bound, cnt_q <= (QAW+1)'(QDEPTH), "queue count past depth")
	`QAU_ASSERT(a_q_empty_ptr, (cnt_q == '0) |-> (wr_q == rd_q), "empty queue with split pointers")
	`QAU_ASSERT_NEXT(a_q_fill, push && !pop, cnt_q == $past(cnt_q) + 1'b1, "push not counted")
endmodule

### rtl/qau_back.sv
// back end: multiplier stage, fast combine, iterative sqrt and divide, output register
// depends on qau_pkg and assert_macros.svh
`include "assert_macros.svh"
module qau_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	output logic                  q_ready,
	input  qau_pkg::item_t        q_data,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [qau_pkg::ODW-1:0] m_axis_tdata  // r_w r_x r_y r_z overflow zero_norm
);
	import qau_pkg::*;

	// multiplier stage
	logic                   v_s1;
	logic [AW-1:0]          act_s1;
	logic                   slow_s1;
	logic signed [DW-1:0]   a_s1 [4];
	logic signed [DW-1:0]   b_s1 [4];
	logic signed [2*DW-1:0] p_s1 [16];

	// iterative unit
	logic                   busy_q;
	logic                   inv_q;
	logic [CW-1:0]          cnt_q;
	logic [2*RW-1:0]        sq_q;
	logic [RW+1:0]          rem_q;
	logic [RW-1:0]          root_q;
	logic [SW-1:0]          den_q;
	logic [NW-1:0]          num_q [4];
	logic [SW-1:0]          drem_q [4];
	logic                   neg_q [4];

	// output register
	logic                   out_valid_q;
	comp_t                  r_q [4];
	logic                   ovf_q;
	logic                   zn_q;

	logic [SW-1:0]          sumsq;
	logic                   s1_iter;
	logic                   out_free;
	logic                   done;
	logic                   s1_go;
	logic                   out_load;
	logic                   iter_load;

	logic signed [PW-1:0]   t [4];
	sat_t                   fs [4];
	comp_t                  f_r [4];
	logic                   f_ovf;
	logic                   f_zn;

	logic [RW+3:0]          nrem;
	logic [RW+3:0]          trial;
	logic [SW:0]            nr [4];
	logic [RW:0]            root_rnd;
	sat_t                   ns;
	logic [NW:0]            qr [4];
	logic signed [XW-1:0]   qx [4];
	sat_t                   ds [4];
	comp_t                  i_r [4];
	logic                   i_ovf;
	logic [DW-1:0]          mag [4];

	assign sumsq = SW'(p_s1[0]) + SW'(p_s1[5]) + SW'(p_s1[10]) + SW'(p_s1[15]);
	assign s1_iter = slow_s1 && !(act_s1 == ACT_INV && sumsq == '0);
	assign out_free = !out_valid_q || m_axis_tready;
	assign done = busy_q && (cnt_q == '0);
	assign s1_go = v_s1 && !busy_q && (s1_iter || out_free);
	assign out_load = (s1_go && !s1_iter) || (done && out_free);
	assign iter_load = s1_go && s1_iter;
	assign q_ready = !v_s1 || s1_go;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = ODW'({zn_q, ovf_q, r_q[3], r_q[2], r_q[1], r_q[0]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (q_ready) begin
			v_s1 <= q_valid;
		end
	end

	// squares for norm and inverse share the diagonal products
	always_ff @(posedge clk) begin
		if (q_ready && q_valid) begin
			act_s1 <= q_data.act;
			slow_s1 <= q_data.slow;
			for (int i = 0; i < 4; i++) begin
				a_s1[i] <= q_data.a[i];
				b_s1[i] <= q_data.slow ? q_data.a[i] : q_data.b[i];
				for (int j = 0; j < 4; j++) begin
					p_s1[i*4+j] <= $signed(q_data.a[i]) *
						$signed(q_data.slow ? q_data.a[j] : q_data.b[j]);
				end
			end
		end
	end

	// ops that bypass the iterative unit
	always_comb begin
		t[0] = PW'(p_s1[0]) - PW'(p_s1[5]) - PW'(p_s1[10]) - PW'(p_s1[15]);
		t[1] = PW'(p_s1[1]) + PW'(p_s1[4]) + PW'(p_s1[11]) - PW'(p_s1[14]);
		t[2] = PW'(p_s1[2]) - PW'(p_s1[7]) + PW'(p_s1[8]) + PW'(p_s1[13]);
		t[3] = PW'(p_s1[3]) + PW'(p_s1[6]) - PW'(p_s1[9]) + PW'(p_s1[12]);
		f_zn = 1'b0;
		for (int i = 0; i < 4; i++) begin
			fs[i] = '0;
		end
		case (act_s1)
			ACT_MUL: begin
				for (int i = 0; i < 4; i++) fs[i] = saturate(round_frac(t[i]));
			end
			ACT_ADD: begin
				for (int i = 0; i < 4; i++) fs[i] = saturate(XW'(a_s1[i]) + XW'(b_s1[i]));
			end
			ACT_SUB: begin
				for (int i = 0; i < 4; i++) fs[i] = saturate(XW'(a_s1[i]) - XW'(b_s1[i]));
			end
			ACT_CONJ: begin
				fs[0] = saturate(XW'(a_s1[0]));
				for (int i = 1; i < 4; i++) fs[i] = saturate(-XW'(a_s1[i]));
			end
			ACT_INV: begin
				f_zn = 1'b1;
			end
			default: begin
				f_zn = 1'b0;
			end
		endcase
		f_ovf = fs[0].ovf || fs[1].ovf || fs[2].ovf || fs[3].ovf;
		for (int i = 0; i < 4; i++) f_r[i] = fs[i].v;
	end

	// one root bit and one quotient bit per lane each cycle
	always_comb begin
		nrem = {rem_q, sq_q[2*RW-1 -: 2]};
		trial = {2'b00, root_q, 2'b01};
		for (int i = 0; i < 4; i++) begin
			nr[i] = {drem_q[i], num_q[i][NW-1]};
			mag[i] = a_s1[i][DW-1] ? DW'(-a_s1[i]) : DW'(a_s1[i]);
		end
		root_rnd = {1'b0, root_q} + (RW+1)'(rem_q > (RW+2)'(root_q));
		ns = saturate(XW'(root_rnd));
		for (int i = 0; i < 4; i++) begin
			qr[i] = {1'b0, num_q[i]} + (NW+1)'({drem_q[i], 1'b0} >= {1'b0, den_q});
			qx[i] = XW'(qr[i]);
			ds[i] = saturate(neg_q[i] ? -qx[i] : qx[i]);
		end
		if (inv_q) begin
			for (int i = 0; i < 4; i++) i_r[i] = ds[i].v;
			i_ovf = ds[0].ovf || ds[1].ovf || ds[2].ovf || ds[3].ovf;
		end else begin
			i_r[0] = ns.v;
			for (int i = 1; i < 4; i++) i_r[i] = '0;
			i_ovf = ns.ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (iter_load) begin
			busy_q <= 1'b1;
			cnt_q <= (act_s1 == ACT_INV) ? CW'(NW) : CW'(RW);
		end else if (done && out_free) begin
			busy_q <= 1'b0;
		end else if (busy_q && !done) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (iter_load) begin
			inv_q <= act_s1 == ACT_INV;
			sq_q <= (2*RW)'(sumsq);
			rem_q <= '0;
			root_q <= '0;
			den_q <= sumsq;
			for (int i = 0; i < 4; i++) begin
				num_q[i] <= NW'(mag[i]) << (2*FB);
				drem_q[i] <= '0;
				neg_q[i] <= a_s1[i][DW-1] ^ (i != 0);
			end
		end else if (busy_q && !done) begin
			sq_q <= sq_q << 2;
			if (nrem >= trial) begin
				rem_q <= (RW+2)'(nrem - trial);
				root_q <= {root_q[RW-2:0], 1'b1};
			end else begin
				rem_q <= (RW+2)'(nrem);
				root_q <= {root_q[RW-2:0], 1'b0};
			end
			for (int i = 0; i < 4; i++) begin
				if (nr[i] >= {1'b0, den_q}) begin
					drem_q[i] <= SW'(nr[i] - {1'b0, den_q});
					num_q[i] <= {num_q[i][NW-2:0], 1'b1};
				end else begin
					drem_q[i] <= SW'(nr[i]);
					num_q[i] <= {num_q[i][NW-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (busy_q) begin
				r_q <= i_r;
				ovf_q <= i_ovf;
				zn_q <= 1'b0;
			end else begin
				r_q <= f_r;
				ovf_q <= f_ovf;
				zn_q <= f_zn;
			end
		end
	end

	`QAU_ASSERT(a_b_cnt, busy_q |-> (cnt_q <= CW'(NW)), "iteration count out of range")
	`QAU_ASSERT(a_b_fin, $fell(busy_q) |-> out_valid_q, "iterative result not delivered")
	`QAU_ASSERT(a_b_zn, (out_valid_q && zn_q) |-> (!ovf_q && r_q[0] == '0 && r_q[3] == '0), "zero norm with data")
endmodule

### rtl/quaternion_arithmetic_unit.sv
// path: an input beat passes the front register, the queue, the multiplier stage and
// the output register; norm and inverse (but for an inverse of zero) also pass the iterative unit
// throughput: one beat per cycle for the other ops while the output is not stalled and the
// iterative unit is idle; it holds the back end at one root bit or one quotient bit per cycle
// reset: arst_n clears all valid flags, the queue and the iteration control
module quaternion_arithmetic_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [qau_pkg::IDW-1:0] s_axis_tdata,  // a_w a_x a_y a_z b_w b_x b_y b_z
	input  logic [qau_pkg::AW-1:0]  s_axis_tuser,  // action
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [qau_pkg::ODW-1:0] m_axis_tdata   // r_w r_x r_y r_z overflow zero_norm
);
	import qau_pkg::*;

	logic  f_valid;
	logic  f_ready;
	item_t f_data;
	logic  b_valid;
	logic  b_ready;
	item_t b_data;

	qau_front u_front (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.q_valid(f_valid), .q_ready(f_ready), .q_data(f_data)
	);

	qau_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
		.out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
	);

	qau_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(b_valid), .q_ready(b_ready), .q_data(b_data),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);
endmodule

### tb/quaternion_arithmetic_unit_tb.sv
// self-checking testbench for quaternion_arithmetic_unit: directed table, then random beats
// expected results come from the table or a bit-exact fixed-point quaternion predictor; needs qau_pkg
`timescale 1ns / 1ps

module quaternion_arithmetic_unit_tb;
	import qau_pkg::*;

	localparam int N_RANDOM = 1130;
	localparam logic [DW-1:0] MAXP = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] MINN = {1'b1, {(DW-1){1'b0}}};
	localparam logic [DW-1:0] ONE  = 1 << FB;
	localparam logic [AW-1:0] ACT_SPARE6 = 3'd6;
	localparam logic [AW-1:0] ACT_SPARE7 = 3'd7;

	typedef logic [3:0][DW-1:0] quat_t;   // element 0 is w
	typedef logic signed [127:0] wide_t;

	typedef struct {
		quat_t r;
		logic  ovf;
		logic  zn;
	} qres_t;

	typedef struct {
		logic [AW-1:0] act;
		quat_t         a;
		quat_t         b;
		bit            typed;
		qres_t         res;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [IDW-1:0] s_axis_tdata = '0;
	logic [AW-1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [ODW-1:0] m_axis_tdata;

	qres_t pending_results[$];
	int errors = 0;
	int n_results = 0;
	int n_ops[8];
	bit no_idle = 0;

	quaternion_arithmetic_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #5 clk = ~clk;

	function automatic quat_t q(input logic [DW-1:0] w, x, y, z);
		quat_t v;
		v[0] = w; v[1] = x; v[2] = y; v[3] = z;
		return v;
	endfunction

	function automatic logic [DW-1:0] clamp(input wide_t v, inout logic ovf);
		if (v > wide_t'($signed(MAXP))) begin
			ovf = 1;
			return MAXP;
		end
		if (v < wide_t'($signed(MINN))) begin
			ovf = 1;
			return MINN;
		end
		return v[DW-1:0];
	endfunction

	// drop fraction bits, ties away from zero
	function automatic wide_t round_q(input wide_t t);
		wide_t m;
		m = t < 0 ? -t : t;
		m = (m + (wide_t'(1) << (FB-1))) >>> FB;
		return t < 0 ? -m : m;
	endfunction

	function automatic qres_t quat_predict(input logic [AW-1:0] act, input quat_t a, b);
		qres_t o;
		wide_t sa[4], sb[4], t[4];
		wide_t s, rt, c, rem, num, qt;
		bit neg;
		o.r = '0; o.ovf = 0; o.zn = 0;
		for (int i = 0; i < 4; i++) begin
			sa[i] = wide_t'($signed(a[i]));
			sb[i] = wide_t'($signed(b[i]));
		end
		s = 0;
		for (int i = 0; i < 4; i++) s = s + sa[i]*sa[i];
		case (act)
			ACT_MUL: begin
				t[0] = sa[0]*sb[0] - sa[1]*sb[1] - sa[2]*sb[2] - sa[3]*sb[3];
				t[1] = sa[0]*sb[1] + sa[1]*sb[0] + sa[2]*sb[3] - sa[3]*sb[2];
				t[2] = sa[0]*sb[2] - sa[1]*sb[3] + sa[2]*sb[0] + sa[3]*sb[1];
				t[3] = sa[0]*sb[3] + sa[1]*sb[2] - sa[2]*sb[1] + sa[3]*sb[0];
				for (int i = 0; i < 4; i++) o.r[i] = clamp(round_q(t[i]), o.ovf);
			end
			ACT_ADD, ACT_SUB: begin
				for (int i = 0; i < 4; i++)
					o.r[i] = clamp(act == ACT_ADD ? sa[i] + sb[i] : sa[i] - sb[i], o.ovf);
			end
			ACT_CONJ: begin
				o.r[0] = clamp(sa[0], o.ovf);
				for (int i = 1; i < 4; i++) o.r[i] = clamp(-sa[i], o.ovf);
			end
			ACT_NORM: begin
				rt = 0;
				for (int k = 63; k >= 0; k--) begin
					c = rt | (wide_t'(1) << k);
					if (c*c <= s) rt = c;
				end
				rem = s - rt*rt;
				if (rem > rt) rt = rt + 1;
				o.r[0] = clamp(rt, o.ovf);
			end
			ACT_INV: begin
				if (s == 0) begin
					o.zn = 1;
				end else begin
					for (int i = 0; i < 4; i++) begin
						neg = (sa[i] < 0) != (i != 0);
						num = (sa[i] < 0 ? -sa[i] : sa[i]) << (2*FB);
						qt = num / s;
						rem = num % s;
						if (rem >= s - rem) qt = qt + 1;
						o.r[i] = clamp(neg ? -qt : qt, o.ovf);
					end
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	function automatic logic [DW-1:0] rand_comp();
		int k;
		k = $urandom_range(99);
		if (k < 40) return $urandom;
		if (k < 75) return DW'($signed($urandom_range(8*ONE)) - $signed(4*ONE));
		if (k < 85) return DW'($signed($urandom_range(64)) - 32);
		case ($urandom_range(3))
			0: return MAXP;
			1: return MINN;
			2: return '0;
			default: return ONE;
		endcase
	endfunction

	task automatic send_beat(input logic [AW-1:0] act, input quat_t a, b,
			input bit typed, input qres_t typed_res);
		while (!no_idle && $urandom_range(99) < 31) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= act;
		s_axis_tdata <= {b, a};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_results.push_back(typed ? typed_res : quat_predict(act, a, b));
		n_ops[act]++;
	endtask

	// result side: random stall outside the no-idle stretch, compare each beat with the oldest expectation
	always @(posedge clk) begin
		qres_t e;
		if (m_axis_tvalid && m_axis_tready) begin
			n_results++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result beat %h", $time, m_axis_tdata);
				errors++;
			end else begin
				e = pending_results.pop_front();
				for (int i = 0; i < 4; i++)
					if (m_axis_tdata[i*DW +: DW] !== e.r[i]) begin
						$display("%0t: component %0d expected %h actual %h", $time, i, e.r[i],
							m_axis_tdata[i*DW +: DW]);
						errors++;
					end
				if (m_axis_tdata[4*DW] !== e.ovf) begin
					$display("%0t: overflow expected %b actual %b", $time, e.ovf,
						m_axis_tdata[4*DW]);
					errors++;
				end
				if (m_axis_tdata[4*DW+1] !== e.zn) begin
					$display("%0t: zero_norm expected %b actual %b", $time, e.zn,
						m_axis_tdata[4*DW+1]);
					errors++;
				end
			end
		end
		m_axis_tready <= no_idle || ($urandom_range(99) >= 31);
	end

	initial begin
		#5ms;
		$display("timeout with %0d results outstanding", pending_results.size());
		$display("** quaternion_arithmetic_unit: FAILED **");
		$finish;
	end

	initial begin
		row_t rows[$];
		qres_t nz;
		logic [AW-1:0] act;
		quat_t a, b;
		int k, waited;
		nz.r = '0; nz.ovf = 0; nz.zn = 0;

		rows.push_back('{ACT_ADD, q(MAXP, 0, 0, 0), q(ONE, 0, 0, 0), 1, '{q(MAXP, 0, 0, 0), 1, 0}});
		rows.push_back('{ACT_SUB, q(MINN, 0, 0, 0), q(ONE, 0, 0, 0), 1, '{q(MINN, 0, 0, 0), 1, 0}});
		rows.push_back('{ACT_ADD, q(MINN, MINN, MINN, MINN), q(MINN, MINN, MINN, MINN), 1,
			'{q(MINN, MINN, MINN, MINN), 1, 0}});
		rows.push_back('{ACT_CONJ, q(1, MINN, MINN, MINN), q(ONE, 0, 0, 0), 1,
			'{q(1, MAXP, MAXP, MAXP), 1, 0}});
		rows.push_back('{ACT_CONJ, q(ONE, ONE, -ONE, 0), '0, 1, '{q(ONE, -ONE, ONE, 0), 0, 0}});
		rows.push_back('{ACT_NORM, '0, q(ONE, ONE, ONE, ONE), 1, nz});
		rows.push_back('{ACT_NORM, q(3*ONE, 4*ONE, 0, 0), '0, 1, '{q(5*ONE, 0, 0, 0), 0, 0}});
		rows.push_back('{ACT_NORM, q(MINN, MINN, MINN, MINN), '0, 1, '{q(MAXP, 0, 0, 0), 1, 0}});
		rows.push_back('{ACT_INV, '0, q(MAXP, MINN, ONE, 1), 1, '{'0, 0, 1}});
		rows.push_back('{ACT_INV, q(ONE, 0, 0, 0), '0, 1, '{q(ONE, 0, 0, 0), 0, 0}});
		rows.push_back('{ACT_INV, q(2*ONE, 0, 0, 0), '0, 1, '{q(ONE/2, 0, 0, 0), 0, 0}});
		rows.push_back('{ACT_MUL, q(0, ONE, 0, 0), q(0, 0, ONE, 0), 1, '{q(0, 0, 0, ONE), 0, 0}});
		// product ties round away from zero
		rows.push_back('{ACT_MUL, q(1, 0, 0, 0), q(ONE/2, 0, 0, 0), 1, '{q(1, 0, 0, 0), 0, 0}});
		rows.push_back('{ACT_MUL, q(-1, 0, 0, 0), q(ONE/2, 0, 0, 0), 1, '{q(-1, 0, 0, 0), 0, 0}});
		rows.push_back('{ACT_SPARE6, q(MAXP, MINN, ONE, 5), q(MINN, 1, 2, 3), 1, nz});
		rows.push_back('{ACT_SPARE7, q(ONE, ONE, ONE, ONE), q(MAXP, MAXP, MAXP, MAXP), 1, nz});
		rows.push_back('{ACT_MUL, q(MAXP, MAXP, MAXP, MAXP), q(MAXP, MAXP, MAXP, MAXP), 0, nz});
		rows.push_back('{ACT_MUL, q(MINN, MINN, MINN, MINN), q(MINN, MAXP, MINN, MAXP), 0, nz});
		rows.push_back('{ACT_INV, q(1, 0, 0, 0), '0, 0, nz});
		rows.push_back('{ACT_INV, q(MINN, MINN, MAXP, 1), '0, 0, nz});
		rows.push_back('{ACT_INV, q(ONE, -ONE, 3*ONE, -7), '0, 0, nz});
		rows.push_back('{ACT_NORM, q(MAXP, 1, -1, ONE), '0, 0, nz});
		rows.push_back('{ACT_SUB, q(MAXP, 0, ONE, MINN), q(MINN, MINN, -ONE, MAXP), 0, nz});

		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (rows[i])
			send_beat(rows[i].act, rows[i].a, rows[i].b, rows[i].typed, rows[i].res);

		for (int n = 0; n < N_RANDOM; n++) begin
			no_idle = (n >= 400 && n < 560);
			if (n == 700) begin
				s_axis_tvalid <= 0;
				@(posedge clk);
				while (pending_results.size() != 0) @(posedge clk);
			end
			k = $urandom_range(99);
			if (k < 70) act = AW'($urandom_range(3));
			else if (k < 82) act = ACT_NORM;
			else if (k < 96) act = ACT_INV;
			else act = AW'($urandom_range(7, 6));
			for (int i = 0; i < 4; i++) begin
				a[i] = rand_comp();
				b[i] = rand_comp();
			end
			if (act == ACT_INV && $urandom_range(19) == 0) a = '0;
			send_beat(act, a, b, 0, nz);
		end
		s_axis_tvalid <= 0;

		waited = 0;
		while (pending_results.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (100) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, pending_results.size());
			errors += pending_results.size();
		end

		$display("covered %0d beats in, %0d results out, %0d mismatches", rows.size() + N_RANDOM,
			n_results, errors);
		$display("ops: mul %0d add %0d sub %0d conj %0d norm %0d inv %0d spare %0d",
			n_ops[0], n_ops[1], n_ops[2], n_ops[3], n_ops[4], n_ops[5], n_ops[6] + n_ops[7]);
		if (errors == 0) begin
			$display("** quaternion_arithmetic_unit: PASSED **");
		end else begin
			$display("** quaternion_arithmetic_unit: FAILED **");
		end
		$finish;
	end
endmodule
